FILE: rtl/vrp_pkg.sv
// Shared types, widths and helpers for the vertex rotate and project pipeline.
// No dependencies; every other file refers to this package by scoped names.
package vrp_pkg;

  localparam int COORD_W   = 16;  // input vertex coordinate, signed Q8.8
  localparam int TRIG_W    = 16;  // cosine or sine, signed Q1.14
  localparam int TRIG_FRAC = 14;
  localparam int ROT_W     = 24;  // rotated coordinate, Q8.8 with growth
  localparam int PROD_W    = ROT_W + TRIG_W;
  localparam int SHIFT_W   = 11;
  localparam int VDIST_W   = 10;
  localparam int HALF_W    = 12;
  localparam int CFG_W     = 32;
  localparam int POS_W     = 26;  // translated coordinate and depth
  localparam int SCALE_W   = POS_W + HALF_W + 1;
  localparam int SUM_W     = SCALE_W + 1;
  localparam int NUM_W     = SUM_W + 1;
  localparam int DEN_W     = POS_W - 1;
  localparam int Q_W       = 16;
  localparam int SCR_W     = 16;

  localparam logic signed [SCR_W-1:0] SCR_MAX = 16'sh7FFF;
  localparam logic signed [SCR_W-1:0] SCR_MIN = 16'sh8000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5,
    REG_VDIST   = 3'd6,
    REG_CENTER  = 3'd7
  } cfg_reg_t;

  // One lane of the restoring divider
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  // Item travelling through the divider
  typedef struct packed {
    div_lane_t        lx;
    div_lane_t        ly;
    logic [DEN_W-1:0] den;
    logic             behind;
  } div_item_t;

  // One quotient bit: subtract the shifted divisor where it fits
  function automatic div_lane_t div_step(div_lane_t l, logic [DEN_W-1:0] den,
                                         int unsigned k);
    logic [NUM_W-1:0] t;
    div_lane_t r;
    t = NUM_W'(den) << k;
    r = l;
    if (l.rem >= t) begin
      r.rem = l.rem - t;
      r.q   = l.q | (Q_W'(1) << k);
    end
    return r;
  endfunction

  // Clamp a magnitude quotient with its sign to the screen range
  function automatic logic [SCR_W-1:0] sat_screen(div_lane_t l);
    logic [SCR_W-1:0] r;
    if (l.neg) begin
      if (l.ovf || (l.q > Q_W'(32768))) r = SCR_MIN;
      else r = SCR_W'(-$signed({1'b0, l.q}));
    end else begin
      if (l.ovf || (l.q > Q_W'(32767))) r = SCR_MAX;
      else r = l.q;
    end
    return r;
  endfunction

endpackage

FILE: rtl/vrp_rotate.sv
// One axis rotation stage: a' = a*c - b*s, b' = b*c + a*s, rounded to Q8.8.
// Depends on vrp_pkg; the third coordinate passes through alongside.
module vrp_rotate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [vrp_pkg::ROT_W-1:0]  a_in,
  input  logic signed [vrp_pkg::ROT_W-1:0]  b_in,
  input  logic signed [vrp_pkg::ROT_W-1:0]  c_in,
  input  logic [vrp_pkg::CFG_W-1:0]         trig,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vrp_pkg::ROT_W-1:0]  a_out,
  output logic signed [vrp_pkg::ROT_W-1:0]  b_out,
  output logic signed [vrp_pkg::ROT_W-1:0]  c_out
);

  localparam logic signed [vrp_pkg::PROD_W:0] HALF =
    (vrp_pkg::PROD_W+1)'(1) << (vrp_pkg::TRIG_FRAC - 1);

  logic signed [vrp_pkg::TRIG_W-1:0] cs;
  logic signed [vrp_pkg::TRIG_W-1:0] sn;
  logic signed [vrp_pkg::PROD_W-1:0] ac, bs, bc, as_;
  logic signed [vrp_pkg::PROD_W:0]   sa, sb, ra, rb;

  // Multiply, sum and round in one stage
  always_comb begin
    cs  = $signed(trig[31:16]);
    sn  = $signed(trig[15:0]);
    ac  = a_in * cs;
    bs  = b_in * sn;
    bc  = b_in * cs;
    as_ = a_in * sn;
    sa  = (vrp_pkg::PROD_W+1)'(ac) - (vrp_pkg::PROD_W+1)'(bs);
    sb  = (vrp_pkg::PROD_W+1)'(bc) + (vrp_pkg::PROD_W+1)'(as_);
    ra  = (sa + HALF) >>> vrp_pkg::TRIG_FRAC;
    rb  = (sb + HALF) >>> vrp_pkg::TRIG_FRAC;
  end

  assign in_ready = !out_valid || out_ready;

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load payload on each transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_out <= ra[vrp_pkg::ROT_W-1:0];
      b_out <= rb[vrp_pkg::ROT_W-1:0];
      c_out <= c_in;
    end
  end

endmodule

FILE: rtl/vrp_project.sv
// Translation, depth and projection numerators, then sign and magnitude set-up.
// Depends on vrp_pkg; feeds vrp_divide with a div_item_t.
module vrp_project (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [vrp_pkg::ROT_W-1:0]  x_in,
  input  logic signed [vrp_pkg::ROT_W-1:0]  y_in,
  input  logic signed [vrp_pkg::ROT_W-1:0]  z_in,
  input  logic [vrp_pkg::SHIFT_W-1:0]       shift_x,
  input  logic [vrp_pkg::SHIFT_W-1:0]       shift_y,
  input  logic [vrp_pkg::SHIFT_W-1:0]       shift_z,
  input  logic [vrp_pkg::VDIST_W-1:0]       view_distance,
  input  logic [vrp_pkg::HALF_W-1:0]        half_w,
  input  logic [vrp_pkg::HALF_W-1:0]        half_h,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vrp_pkg::div_item_t                out_item
);

  localparam int P = vrp_pkg::POS_W;

  logic signed [P-1:0]                 x2, y2, d;
  logic signed [vrp_pkg::HALF_W:0]     hw_s, hh_s;
  logic signed [vrp_pkg::SCALE_W-1:0]  px_c, py_c, pwd_c, phd_c;

  // Stage one registers
  logic                                v1;
  logic                                rdy1;
  logic signed [vrp_pkg::SCALE_W-1:0]  px, py, pwd, phd;
  logic signed [P-1:0]                 d1;

  logic signed [vrp_pkg::SUM_W-1:0]    nx, ny;
  logic [vrp_pkg::SUM_W-1:0]           mx, my;
  logic [vrp_pkg::NUM_W-1:0]           lim;
  vrp_pkg::div_item_t                  item_c;

  // Translate, form depth and the four products
  always_comb begin
    x2 = P'(x_in) + P'($signed({shift_x, 8'b0}));
    y2 = P'(y_in) + P'($signed({shift_y, 8'b0}));
    d  = P'($signed({1'b0, view_distance, 8'b0})) + P'(z_in)
       + P'($signed({shift_z, 8'b0}));
    hw_s  = $signed({1'b0, half_w});
    hh_s  = $signed({1'b0, half_h});
    px_c  = x2 * hh_s;
    py_c  = y2 * hh_s;
    pwd_c = d * hw_s;
    phd_c = d * hh_s;
  end

  assign in_ready = !v1 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px  <= px_c;
      py  <= py_c;
      pwd <= pwd_c;
      phd <= phd_c;
      d1  <= d;
    end
  end

  // Sum numerators, split sign and magnitude, check for overflow
  always_comb begin
    nx  = vrp_pkg::SUM_W'(px) + vrp_pkg::SUM_W'(pwd);
    ny  = vrp_pkg::SUM_W'(py) + vrp_pkg::SUM_W'(phd);
    mx  = nx[vrp_pkg::SUM_W-1] ? vrp_pkg::SUM_W'(-nx) : vrp_pkg::SUM_W'(nx);
    my  = ny[vrp_pkg::SUM_W-1] ? vrp_pkg::SUM_W'(-ny) : vrp_pkg::SUM_W'(ny);
    item_c.behind = (d1 <= 0);
    item_c.den    = item_c.behind ? vrp_pkg::DEN_W'(1) : d1[vrp_pkg::DEN_W-1:0];
    lim           = vrp_pkg::NUM_W'(item_c.den) << vrp_pkg::Q_W;
    item_c.lx.rem = vrp_pkg::NUM_W'(mx);
    item_c.lx.q   = '0;
    item_c.lx.neg = nx[vrp_pkg::SUM_W-1];
    item_c.lx.ovf = (vrp_pkg::NUM_W'(mx) >= lim);
    item_c.ly.rem = vrp_pkg::NUM_W'(my);
    item_c.ly.q   = '0;
    item_c.ly.neg = ny[vrp_pkg::SUM_W-1];
    item_c.ly.ovf = (vrp_pkg::NUM_W'(my) >= lim);
  end

  assign rdy1 = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy1) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy1) begin
      out_item <= item_c;
    end
  end

endmodule

FILE: rtl/vrp_divide.sv
// Pipelined restoring divider, one quotient bit per stage for both lanes.
// Depends on vrp_pkg (div_item_t, div_step).
module vrp_divide (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrp_pkg::div_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output vrp_pkg::div_item_t out_item
);

  localparam int N = vrp_pkg::Q_W;

  logic               vld [N];
  logic               rdy [N];
  vrp_pkg::div_item_t stg [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic               src_v;
    logic               dst_r;
    vrp_pkg::div_item_t src;
    vrp_pkg::div_item_t nxt;

    if (i == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = in_item;
    end else begin : g_mid
      assign src_v = vld[i-1];
      assign src   = stg[i-1];
    end

    if (i == N - 1) begin : g_last
      assign dst_r = out_ready;
    end else begin : g_inner
      assign dst_r = rdy[i+1];
    end

    // Resolve quotient bit N-1-i
    always_comb begin
      nxt    = src;
      nxt.lx = vrp_pkg::div_step(src.lx, src.den, N - 1 - i);
      nxt.ly = vrp_pkg::div_step(src.ly, src.den, N - 1 - i);
    end

    assign rdy[i] = !vld[i] || dst_r;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (src_v && rdy[i]) begin
        stg[i] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[N-1];
  assign out_item  = stg[N-1];

endmodule

FILE: rtl/vertex_rotate_project.sv
// Vertex rotate and perspective project: rotates each Q8.8 vertex about X, then
// Y, then Z, translates it and projects it to screen pixels. Fully pipelined:
// one vertex per clock unless the output stalls: three rotation stages, two
// projection set-up stages, a 16-stage divider, one output register. Every
// stage stalls only when its successor is full, so bubbles close up under
// back-pressure. Configuration is written through cfg_we/cfg_addr/cfg_wdata.
module vertex_rotate_project (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // vert_x [15:0], vert_y [31:16], vert_z [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // screen_x [15:0], screen_y [31:16]
  output logic [0:0]  m_tuser,   // behind [0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int R = vrp_pkg::ROT_W;

  logic [31:0]                   rot_x_trig, rot_y_trig, rot_z_trig;
  logic [vrp_pkg::SHIFT_W-1:0]   shift_x, shift_y, shift_z;
  logic [vrp_pkg::VDIST_W-1:0]   view_distance;
  logic [23:0]                   screen_center;

  logic signed [R-1:0] x0, y0, z0;
  logic signed [R-1:0] y1, z1, x1;
  logic signed [R-1:0] x2, z2, y2;
  logic signed [R-1:0] x3, y3, z3;
  logic v1, v2, v3, r1, r2, r3;
  logic vp, rp, vd, rd;
  vrp_pkg::div_item_t pitem, ditem;
  vrp_pkg::cfg_reg_t  reg_sel;

  // Register writes
  assign reg_sel = vrp_pkg::cfg_reg_t'(cfg_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x_trig    <= 32'h4000_0000;
      rot_y_trig    <= 32'h4000_0000;
      rot_z_trig    <= 32'h4000_0000;
      shift_x       <= '0;
      shift_y       <= '0;
      shift_z       <= '0;
      view_distance <= 10'd25;
      screen_center <= {12'd400, 12'd300};
    end else if (cfg_we) begin
      unique case (reg_sel)
        vrp_pkg::REG_ROT_X:   rot_x_trig    <= cfg_wdata;
        vrp_pkg::REG_ROT_Y:   rot_y_trig    <= cfg_wdata;
        vrp_pkg::REG_ROT_Z:   rot_z_trig    <= cfg_wdata;
        vrp_pkg::REG_SHIFT_X: shift_x       <= cfg_wdata[vrp_pkg::SHIFT_W-1:0];
        vrp_pkg::REG_SHIFT_Y: shift_y       <= cfg_wdata[vrp_pkg::SHIFT_W-1:0];
        vrp_pkg::REG_SHIFT_Z: shift_z       <= cfg_wdata[vrp_pkg::SHIFT_W-1:0];
        vrp_pkg::REG_VDIST:   view_distance <= cfg_wdata[vrp_pkg::VDIST_W-1:0];
        vrp_pkg::REG_CENTER:  screen_center <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Unpack and widen the input vertex
  assign x0 = R'($signed(s_tdata[15:0]));
  assign y0 = R'($signed(s_tdata[31:16]));
  assign z0 = R'($signed(s_tdata[47:32]));

  // Rotate about X (y, z)
  vrp_rotate u_rot_x (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .a_in(y0), .b_in(z0), .c_in(x0), .trig(rot_x_trig),
    .out_valid(v1), .out_ready(r1),
    .a_out(y1), .b_out(z1), .c_out(x1)
  );

  // Rotate about Y (x, z)
  vrp_rotate u_rot_y (
    .clk(clk), .rst(rst),
    .in_valid(v1), .in_ready(r1),
    .a_in(x1), .b_in(z1), .c_in(y1), .trig(rot_y_trig),
    .out_valid(v2), .out_ready(r2),
    .a_out(x2), .b_out(z2), .c_out(y2)
  );

  // Rotate about Z (x, y)
  vrp_rotate u_rot_z (
    .clk(clk), .rst(rst),
    .in_valid(v2), .in_ready(r2),
    .a_in(x2), .b_in(y2), .c_in(z2), .trig(rot_z_trig),
    .out_valid(v3), .out_ready(r3),
    .a_out(x3), .b_out(y3), .c_out(z3)
  );

  vrp_project u_proj (
    .clk(clk), .rst(rst),
    .in_valid(v3), .in_ready(r3),
    .x_in(x3), .y_in(y3), .z_in(z3),
    .shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z),
    .view_distance(view_distance),
    .half_w(screen_center[23:12]), .half_h(screen_center[11:0]),
    .out_valid(vp), .out_ready(rp), .out_item(pitem)
  );

  vrp_divide u_div (
    .clk(clk), .rst(rst),
    .in_valid(vp), .in_ready(rp), .in_item(pitem),
    .out_valid(vd), .out_ready(rd), .out_item(ditem)
  );

  // Output register: saturate, or return the centre when behind the viewer
  assign rd = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd) begin
      m_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (vd && rd) begin
      if (ditem.behind) begin
        m_tdata <= {4'b0, screen_center[11:0], 4'b0, screen_center[23:12]};
      end else begin
        m_tdata <= {vrp_pkg::sat_screen(ditem.ly), vrp_pkg::sat_screen(ditem.lx)};
      end
      m_tuser <= ditem.behind;
    end
  end

endmodule

FILE: bench/vrp_checker.sv
// Scoreboard for vertex_rotate_project: watches the vertex and screen channels and
// the register port, predicts each screen point and compares it. Depends on vrp_pkg.
module vrp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        behind;
  } screen_pt_t;

  logic [31:0] trig_x, trig_y, trig_z;
  logic [10:0] off_x, off_y, off_z;
  logic [9:0]  view_dist;
  logic [23:0] centre;
  screen_pt_t  expected_pts[$];

  // Round a Q.22 sum back to Q8.8, ties toward plus infinity, and bound it
  function automatic longint requant(longint p);
    longint r;
    r = (p + 64'sd8192) >>> 14;
    if (r > (64'sd1 << 40)) r = 64'sd1 << 40;
    if (r < -(64'sd1 << 40)) r = -(64'sd1 << 40);
    return r;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic screen_pt_t project_vertex(logic [47:0] v);
    longint x, y, z, t, c, s, hw, hh, d;
    screen_pt_t r;
    x = longint'($signed(v[15:0]));
    y = longint'($signed(v[31:16]));
    z = longint'($signed(v[47:32]));
    hw = longint'(centre[23:12]);
    hh = longint'(centre[11:0]);
    // about X
    c = longint'($signed(trig_x[31:16])); s = longint'($signed(trig_x[15:0]));
    t = requant(y * c - z * s); z = requant(z * c + y * s); y = t;
    // about Y
    c = longint'($signed(trig_y[31:16])); s = longint'($signed(trig_y[15:0]));
    t = requant(x * c - z * s); z = requant(z * c + x * s); x = t;
    // about Z
    c = longint'($signed(trig_z[31:16])); s = longint'($signed(trig_z[15:0]));
    t = requant(x * c - y * s); y = requant(y * c + x * s); x = t;
    x += longint'($signed(off_x)) * 256;
    y += longint'($signed(off_y)) * 256;
    z += longint'($signed(off_z)) * 256;
    d = longint'(view_dist) * 256 + z;
    if (d <= 0) begin
      r.sx = clip16(hw); r.sy = clip16(hh); r.behind = 1'b1;
    end else begin
      r.sx = clip16((x * hh + hw * d) / d);
      r.sy = clip16((y * hh + hh * d) / d);
      r.behind = 1'b0;
    end
    return r;
  endfunction

  assign pending = expected_pts.size();

  always @(posedge clk) begin
    screen_pt_t e;
    if (rst) begin
      trig_x <= 32'h4000_0000; trig_y <= 32'h4000_0000; trig_z <= 32'h4000_0000;
      off_x <= '0; off_y <= '0; off_z <= '0;
      view_dist <= 10'd25; centre <= {12'd400, 12'd300};
      expected_pts.delete();
      errors <= 0;
    end else begin
      // track register writes
      if (cfg_we) begin
        case (vrp_pkg::cfg_reg_t'(cfg_addr))
          vrp_pkg::REG_ROT_X:   trig_x    <= cfg_wdata;
          vrp_pkg::REG_ROT_Y:   trig_y    <= cfg_wdata;
          vrp_pkg::REG_ROT_Z:   trig_z    <= cfg_wdata;
          vrp_pkg::REG_SHIFT_X: off_x     <= cfg_wdata[10:0];
          vrp_pkg::REG_SHIFT_Y: off_y     <= cfg_wdata[10:0];
          vrp_pkg::REG_SHIFT_Z: off_z     <= cfg_wdata[10:0];
          vrp_pkg::REG_VDIST:   view_dist <= cfg_wdata[9:0];
          vrp_pkg::REG_CENTER:  centre    <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      // predict each accepted vertex
      if (s_tvalid && s_tready) expected_pts.push_back(project_vertex(s_tdata));
      // compare each delivered point
      if (m_tvalid && m_tready) begin
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected screen point %h/%b", $time, m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          e = expected_pts.pop_front();
          if (e.sx !== m_tdata[15:0] || e.sy !== m_tdata[31:16]
              || e.behind !== m_tuser[0]) begin
            $display("%0t: mismatch expected x=%h y=%h behind=%b actual x=%h y=%h behind=%b",
                     $time, e.sx, e.sy, e.behind, m_tdata[15:0], m_tdata[31:16], m_tuser[0]);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/tb.sv
// Stimulus and verdict for vertex_rotate_project: drives vertices and register
// settings under varied handshake idling. Depends on vrp_pkg and vrp_checker.
module tb;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0] s_tdata;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  int          errors, pending;
  int          send_idle, sink_stall, hold_off, cycles;

  vertex_rotate_project dut (.*);
  vrp_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("vertex_rotate_project test failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready <= 0;
        hold_off--;
      end else m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // Hold one write for a cycle; the caller drops the enable after the last one
  task automatic write_reg(vrp_pkg::cfg_reg_t r, logic [31:0] v);
    cfg_we <= 1; cfg_addr <= r; cfg_wdata <= v;
    @(negedge clk);
  endtask

  // Offer one vertex; valid stays high into the next call unless it idles
  task automatic send_vertex(logic [47:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1; s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_trig();
    int a;
    a = $urandom_range(3);
    if (a == 0) return $urandom;
    // mostly near-unit pairs so depth stays mostly in front
    return {16'($urandom_range(16384, 12000)), 16'($signed($urandom_range(8000)) - 4000)};
  endfunction

  task automatic random_settings(int extreme);
    if (extreme == 1) begin
      write_reg(vrp_pkg::REG_ROT_X, 32'h8000_7FFF);
      write_reg(vrp_pkg::REG_ROT_Y, 32'h7FFF_8000);
      write_reg(vrp_pkg::REG_ROT_Z, 32'hFFFF_FFFF);
      write_reg(vrp_pkg::REG_SHIFT_X, 32'h3FF);
      write_reg(vrp_pkg::REG_SHIFT_Y, 32'h400);
      write_reg(vrp_pkg::REG_SHIFT_Z, 32'h3FF);
      write_reg(vrp_pkg::REG_VDIST, 32'h3FF);
      write_reg(vrp_pkg::REG_CENTER, 32'hFFFFFF);
    end else if (extreme == 2) begin
      write_reg(vrp_pkg::REG_ROT_X, 32'h0000_4000);
      write_reg(vrp_pkg::REG_ROT_Y, 32'h0);
      write_reg(vrp_pkg::REG_ROT_Z, 32'h4000_0000);
      write_reg(vrp_pkg::REG_SHIFT_X, 32'h400);
      write_reg(vrp_pkg::REG_SHIFT_Y, 32'h3FF);
      write_reg(vrp_pkg::REG_SHIFT_Z, 32'h400);
      write_reg(vrp_pkg::REG_VDIST, 32'h0);
      write_reg(vrp_pkg::REG_CENTER, 32'h0);
    end else begin
      write_reg(vrp_pkg::REG_ROT_X, pick_trig());
      write_reg(vrp_pkg::REG_ROT_Y, pick_trig());
      write_reg(vrp_pkg::REG_ROT_Z, pick_trig());
      write_reg(vrp_pkg::REG_SHIFT_X, 32'($signed($urandom_range(200)) - 100));
      write_reg(vrp_pkg::REG_SHIFT_Y, 32'($signed($urandom_range(200)) - 100));
      write_reg(vrp_pkg::REG_SHIFT_Z, 32'($signed($urandom_range(2047)) - 1024));
      write_reg(vrp_pkg::REG_VDIST, $urandom_range(1023));
      write_reg(vrp_pkg::REG_CENTER, $urandom);
    end
    cfg_we <= 0;
  endtask

  initial begin
    logic [47:0] corners[10];
    s_tvalid = 0; s_tdata = '0;
    cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    send_idle = 0; sink_stall = 0; hold_off = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, behind the viewer, saturation
    corners = '{48'h0, {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000, 16'h8000},
                {16'hE700, 16'h0, 16'h0}, {16'hE600, 16'h0, 16'h0},
                {16'h0, 16'h0, 16'h7FFF}, {16'hE701, 16'h8000, 16'h7FFF},
                {16'h0100, 16'h0100, 16'h0100}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
                {16'h5555, 16'hAAAA, 16'h5555}};
    foreach (corners[i]) send_vertex(corners[i]);
    for (int k = 1; k <= 2; k++) begin
      drain();
      random_settings(k);
      foreach (corners[i]) send_vertex(corners[i]);
    end

    // Random phases over idling patterns and settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      random_settings(0);
      case (ph % 4)
        0: begin send_idle = 0;  sink_stall = 0;  end
        1: begin send_idle = 77; sink_stall = 0;  end
        2: begin send_idle = 0;  sink_stall = 77; end
        default: begin send_idle = 33; sink_stall = 33; end
      endcase
      if (ph == 4) hold_off = 200;
      for (int n = 0; n < 180; n++)
        send_vertex({pick_coord(), pick_coord(), pick_coord()});
    end

    drain();
    if (errors == 0) $display("vertex_rotate_project test passed");
    else $display("vertex_rotate_project test failed");
    $finish;
  end
endmodule
